>>> src/length_prefixed_packet_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the length-prefixed packet deframer
// Concurrent checks, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_PACKET_DEFRAMER_CORE_MACROS_SVH
`define LENGTH_PREFIXED_PACKET_DEFRAMER_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define LPPD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lppd assertion failed");
// next-cycle implication
`define LPPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lppd assertion failed");
`else
`define LPPD_ASSERT_NOW(label, clk, rst, ante, cons)
`define LPPD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> src/lppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and codes of the length-prefixed packet deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

   localparam int SESSIONS_DEF  = 64;
   localparam int HEADER_BYTES  = 4;
   localparam int SIDX_W        = 6;
   localparam int LEN_W         = 15;

   localparam logic [LEN_W-1:0] MAX_LEN_RST = 15'd1024;

   // per-session phase codes
   localparam logic [2:0] PH_HDR_FIRST = 3'd0;
   localparam logic [2:0] PH_HDR_LAST  = 3'(HEADER_BYTES - 1);
   localparam logic [2:0] PH_BODY      = 3'(HEADER_BYTES);
   localparam logic [2:0] PH_DROP      = 3'(HEADER_BYTES + 1);

   // result kinds
   localparam logic [1:0] EV_ANNOUNCE = 2'd0;
   localparam logic [1:0] EV_BODY     = 2'd1;
   localparam logic [1:0] EV_OVERSIZE = 2'd2;

   typedef struct packed {
      logic [2:0]       phase;
      logic [31:0]      header;
      logic [LEN_W-1:0] to_go;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              emit;
      logic [1:0]        kind;
      logic signed [15:0] frame_id;
      logic [LEN_W-1:0]  body_length;
      logic [7:0]        body_byte;
      logic              last;
   } event_type;

endpackage

>>> src/lppd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_req_if / lppd_rsp_if
// Valid/ready channels for received bytes and framing results.
// ----------------------------------------------------------------------------
interface lppd_req_if;
   logic       valid;
   logic       ready;
   logic [5:0] session_index;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output session_index, output data_byte,
                   output restart, input ready);
   modport sink   (input valid, input session_index, input data_byte,
                   input restart, output ready);
endinterface

interface lppd_rsp_if;
   logic               valid;
   logic               ready;
   logic [5:0]         out_session;
   logic [1:0]         event_kind;
   logic signed [15:0] frame_id;
   logic [14:0]        body_length;
   logic [7:0]         body_byte;
   logic               last;

   modport source (output valid, output out_session, output event_kind,
                   output frame_id, output body_length, output body_byte,
                   output last, input ready);
   modport sink   (input valid, input out_session, input event_kind,
                   input frame_id, input body_length, input body_byte,
                   input last, output ready);
endinterface

>>> src/lppd_state_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_state_ram
// Per-session framing state memory with registered read, write-back
// forwarding and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module lppd_state_ram #(
   parameter int SESSIONS = lppd_pkg::SESSIONS_DEF,
   parameter int AW       = (SESSIONS > 1) ? $clog2(SESSIONS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  lppd_pkg::entry_type wr_data,
   output lppd_pkg::entry_type rd_entry,
   output logic                busy
);
   import lppd_pkg::*;

   logic [ENTRY_W-1:0] mem [SESSIONS];

   logic [ENTRY_W-1:0] rd_data_ff;
   logic [AW-1:0]      rd_addr_ff;
   logic               clr_active_ff, clr_active_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic               wb_valid_ff;
   logic [AW-1:0]      wb_addr_ff;
   logic [ENTRY_W-1:0] wb_data_ff;

   logic               we;
   logic [AW-1:0]      wa;
   logic [ENTRY_W-1:0] wd;

   always_comb begin
      if (clr_active_ff) begin
         we = 1'b1;
         wa = clr_addr_ff;
         wd = '0;
      end else begin
         we = wr_en;
         wa = wr_addr;
         wd = wr_data;
      end
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         if (clr_addr_ff == AW'(SESSIONS - 1)) begin
            clr_active_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // last write kept to cover a read issued on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         wb_valid_ff   <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         if (we) begin
            wb_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         wb_addr_ff <= wa;
         wb_data_ff <= wd;
      end
   end

   assign rd_entry = (wb_valid_ff && (wb_addr_ff == rd_addr_ff)) ?
                     entry_type'(wb_data_ff) : entry_type'(rd_data_ff);
   assign busy     = clr_active_ff;

endmodule

>>> src/lppd_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_framer
// Next-state and result logic for one byte of one session.
// ----------------------------------------------------------------------------
module lppd_framer (
   input  lppd_pkg::entry_type          cur,
   input  logic [7:0]                   data_byte,
   input  logic                         restart,
   input  logic [lppd_pkg::LEN_W-1:0]   max_len,
   output lppd_pkg::entry_type          nxt,
   output lppd_pkg::event_type          evt
);
   import lppd_pkg::*;

   logic [31:0] hdr;
   logic [15:0] len16;

   always_comb begin
      hdr   = cur.header | ({24'd0, data_byte} << {cur.phase[1:0], 3'b000});
      len16 = hdr[31:16];
      nxt   = cur;
      evt   = '0;

      if (restart) begin
         nxt = '0;
      end else if (cur.phase < PH_BODY) begin
         nxt.header = hdr;
         if (cur.phase != PH_HDR_LAST) begin
            nxt.phase = cur.phase + 3'd1;
         end else begin
            evt.emit     = 1'b1;
            evt.frame_id = hdr[15:0];
            if (len16 == 16'd0 || len16[15]) begin
               // empty or negative body
               evt.kind = EV_ANNOUNCE;
               evt.last = 1'b1;
               nxt      = '0;
            end else if (len16[LEN_W-1:0] > max_len) begin
               evt.kind        = EV_OVERSIZE;
               evt.body_length = len16[LEN_W-1:0];
               evt.last        = 1'b1;
               nxt.phase       = PH_DROP;
               nxt.to_go       = '0;
            end else begin
               evt.kind        = EV_ANNOUNCE;
               evt.body_length = len16[LEN_W-1:0];
               nxt.phase       = PH_BODY;
               nxt.to_go       = len16[LEN_W-1:0];
            end
         end
      end else if (cur.phase == PH_BODY) begin
         evt.emit        = 1'b1;
         evt.kind        = EV_BODY;
         evt.frame_id    = cur.header[15:0];
         evt.body_length = cur.header[16 +: LEN_W];
         evt.body_byte   = data_byte;
         if (cur.to_go <= LEN_W'(1)) begin
            evt.last = 1'b1;
            nxt      = '0;
         end else begin
            nxt.to_go = cur.to_go - LEN_W'(1);
         end
      end
   end

endmodule

>>> src/length_prefixed_packet_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_packet_deframer_core
// Per-session deframer for packets with a 4-byte id/length header.
// ----------------------------------------------------------------------------
// req_ch carries one received byte per transfer, tagged with its session, or
// a restart that clears that session. rsp_ch carries at most one result per
// byte: a packet announcement, a body byte or an oversize error. csr_wr_en /
// csr_wr_data set the largest accepted body length (reset 1024).
// Session state lives in one memory, one entry per session; a byte reads it
// on acceptance and the next stage writes it back, with the last write
// forwarded when the same session follows directly.
// Each byte is registered in the working stage, and its result in the rsp_ch output register.
// Throughput: one byte per cycle while rsp_ch is taking results.
// Reset: after reset a clearing sweep zeroes the state memory, one entry a
// cycle; req_ch.ready stays low until the sweep has cleared every entry.
// Stall: while a result waits on rsp_ch, one further byte can be held in the
// working stage; bytes that give no result keep flowing past the stall.
// ----------------------------------------------------------------------------
`include "length_prefixed_packet_deframer_core_macros.svh"

module length_prefixed_packet_deframer_core #(
   parameter int SESSIONS = lppd_pkg::SESSIONS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   lppd_req_if.sink                   req_ch,
   lppd_rsp_if.source                 rsp_ch,
   input  logic                       csr_wr_en,
   input  logic [lppd_pkg::LEN_W-1:0] csr_wr_data
);
   import lppd_pkg::*;

   localparam int AW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;

   logic [LEN_W-1:0]  max_len_ff;

   logic              s1_valid_ff, s1_valid_in;
   logic              s1_in_range_ff;
   logic              s1_restart_ff;
   logic [7:0]        s1_byte_ff;
   logic [SIDX_W-1:0] s1_session_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [SIDX_W-1:0] rsp_session_ff;
   event_type         rsp_evt_ff;

   logic              accept;
   logic              in_range;
   logic              busy;
   logic              rsp_free;
   logic              emit_eff;
   logic              s1_fire;
   entry_type         cur_entry;
   entry_type         nxt_entry;
   event_type         evt;

   assign in_range = 32'(req_ch.session_index) < 32'(SESSIONS);
   assign accept   = req_ch.valid && req_ch.ready;

   lppd_state_ram #(
      .SESSIONS (SESSIONS),
      .AW       (AW)
   ) u_state_ram (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (accept),
      .rd_addr  (AW'(req_ch.session_index)),
      .wr_en    (s1_fire && s1_in_range_ff),
      .wr_addr  (AW'(s1_session_ff)),
      .wr_data  (nxt_entry),
      .rd_entry (cur_entry),
      .busy     (busy)
   );

   lppd_framer u_framer (
      .cur       (cur_entry),
      .data_byte (s1_byte_ff),
      .restart   (s1_restart_ff),
      .max_len   (max_len_ff),
      .nxt       (nxt_entry),
      .evt       (evt)
   );

   assign emit_eff     = s1_in_range_ff && evt.emit;
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && (!emit_eff || rsp_free);
   assign req_ch.ready = !busy && (!s1_valid_ff || s1_fire);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = s1_valid_ff && emit_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= MAX_LEN_RST;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_in_range_ff <= in_range;
         s1_restart_ff  <= req_ch.restart;
         s1_byte_ff     <= req_ch.data_byte;
         s1_session_ff  <= req_ch.session_index;
      end
      if (s1_fire && emit_eff) begin
         rsp_session_ff <= s1_session_ff;
         rsp_evt_ff     <= evt;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_session = rsp_session_ff;
   assign rsp_ch.event_kind  = rsp_evt_ff.kind;
   assign rsp_ch.frame_id    = rsp_evt_ff.frame_id;
   assign rsp_ch.body_length = rsp_evt_ff.body_length;
   assign rsp_ch.body_byte   = rsp_evt_ff.body_byte;
   assign rsp_ch.last        = rsp_evt_ff.last;

   // the working stage is empty for the whole clearing sweep
   `LPPD_ASSERT_NOW(a_clear_stage_empty, clock, reset, busy, !s1_valid_ff)
   // a body byte in range always produces a result next cycle
   `LPPD_ASSERT_NEXT(a_body_emits, clock, reset, s1_fire && s1_in_range_ff && !s1_restart_ff && cur_entry.phase == PH_BODY, rsp_valid_ff)
   // written phase codes stay in the defined set
   `LPPD_ASSERT_NOW(a_phase_legal, clock, reset, s1_fire && s1_in_range_ff, nxt_entry.phase <= PH_DROP)
   // a restart never produces a result
   `LPPD_ASSERT_NOW(a_restart_silent, clock, reset, s1_valid_ff && s1_restart_ff, !emit_eff)

endmodule
